@@ sv/kvclp_pkg.sv @@
// Package for the key-value command line parser.
// Holds command match tables, request kind codes and byte role codes.
// No dependencies.
package kvclp_pkg;

  localparam int unsigned KEY_MAX_DEF = 256;

  localparam int unsigned NUM_CAND   = 8;
  localparam int unsigned NUM_PREFIX = 6;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef logic [3:0] kind_t;
  typedef logic [1:0] role_t;
  typedef logic [7:0] cand_text_t [NUM_CAND][8];
  typedef logic [2:0] cand_len_t [NUM_CAND];
  typedef kind_t cand_kind_t [NUM_CAND];

  localparam kind_t KIND_PARSE = 4'd0;
  localparam kind_t KIND_ARG   = 4'd1;
  localparam kind_t KIND_SET   = 4'd3;

  localparam role_t ROLE_NONE  = 2'd0;
  localparam role_t ROLE_KEY   = 2'd1;
  localparam role_t ROLE_VALUE = 2'd2;

  localparam logic [8:0] KEY_LEN_CAP = 9'd511;

  localparam cand_text_t CAND_TEXT = '{
    '{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"I", "N", "C", "R", " ",  8'h00, 8'h00, 8'h00},
    '{"D", "E", "C", "R", " ",  8'h00, 8'h00, 8'h00},
    '{"U", "R", "L", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"F", "L", "U", "S", "H",  8'h00, 8'h00, 8'h00},
    '{"I", "N", "F", "O", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam cand_len_t CAND_LEN = '{3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4};

  localparam cand_kind_t CAND_KIND = '{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9};

endpackage

@@ sv/kv_command_line_parser.sv @@
// Key-value command line parser: one module, per-byte parse state and result register.
// Depends on kvclp_pkg for match tables and code constants.
// The result for a byte is registered and appears in the cycle after its transaction is accepted.
// Throughput: one byte per cycle; the per-byte state update and the output register
// are the only stages, and a byte is taken whenever the output register is empty or drains.
// Reset (rst, synchronous, active high) clears the parse state to the command phase
// and empties the output register; the parse state also returns there after each last byte.
module kv_command_line_parser #(
  parameter int unsigned KEY_MAX = kvclp_pkg::KEY_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          byte_echo,
  output kvclp_pkg::role_t    byte_role,
  output logic                line_done,
  output kvclp_pkg::kind_t    request_kind,
  output logic [8:0]          key_length,
  output logic [15:0]         value_length
);

  import kvclp_pkg::*;

  localparam int unsigned KeyW = $clog2(KEY_MAX + 1);
  localparam int unsigned ExtW = (KeyW > 9) ? KeyW : 9;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_KEY_START,
    PH_KEY,
    PH_SKIP,
    PH_VAL_START,
    PH_VAL,
    PH_TAIL
  } phase_t;

  phase_t                phase, phase_next;
  logic [2:0]            position, position_next;
  logic [NUM_CAND-1:0]   candidate_mask, candidate_mask_next;
  logic [KeyW-1:0]       key_count, key_count_next;
  logic [15:0]           value_count, value_count_next;
  logic                  arg_error, arg_error_next;
  kind_t                 matched_kind, matched_kind_next;

  role_t                 role_calc;
  kind_t                 kind_calc;
  logic [8:0]            klen_calc;
  logic [15:0]           vlen_calc;
  logic                  missing;
  logic [ExtW-1:0]       key_ext;
  logic                  in_accept;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    phase_next          = phase;
    position_next       = (position == 3'd7) ? position : position + 3'd1;
    candidate_mask_next = candidate_mask;
    key_count_next      = key_count;
    value_count_next    = value_count;
    arg_error_next      = arg_error;
    matched_kind_next   = matched_kind;
    role_calc           = ROLE_NONE;

    case (phase)
      PH_CMD: begin
        for (int i = 0; i < NUM_CAND; i++) begin
          if (candidate_mask[i]) begin
            if (position >= CAND_LEN[i] || CAND_TEXT[i][position] != data_byte) begin
              candidate_mask_next[i] = 1'b0;
            end else if ((position + 3'd1) == CAND_LEN[i]) begin
              if (i < NUM_PREFIX) begin
                matched_kind_next = CAND_KIND[i];
                phase_next        = PH_KEY_START;
              end else if (last_byte) begin
                matched_kind_next = CAND_KIND[i];
                phase_next        = PH_TAIL;
              end else begin
                candidate_mask_next[i] = 1'b0;
              end
            end
          end
        end
        if (phase_next == PH_CMD && candidate_mask_next == '0) begin
          matched_kind_next = KIND_PARSE;
          phase_next        = PH_TAIL;
        end
      end
      PH_KEY_START: begin
        if (data_byte == CHAR_SPACE) begin
          arg_error_next = 1'b1;
          phase_next     = PH_TAIL;
        end else begin
          role_calc      = ROLE_KEY;
          key_count_next = KeyW'(1);
          phase_next     = PH_KEY;
          if (key_count_next >= KeyW'(KEY_MAX)) begin
            phase_next = (matched_kind == KIND_SET) ? PH_SKIP : PH_TAIL;
          end
        end
      end
      PH_KEY: begin
        if (data_byte == CHAR_SPACE) begin
          phase_next = (matched_kind == KIND_SET) ? PH_VAL_START : PH_TAIL;
        end else begin
          role_calc      = ROLE_KEY;
          key_count_next = key_count + KeyW'(1);
          if (key_count_next >= KeyW'(KEY_MAX)) begin
            phase_next = (matched_kind == KIND_SET) ? PH_SKIP : PH_TAIL;
          end
        end
      end
      PH_SKIP: begin
        phase_next = PH_VAL_START;
      end
      PH_VAL_START: begin
        if (data_byte == CHAR_SPACE) begin
          arg_error_next = 1'b1;
          phase_next     = PH_TAIL;
        end else begin
          role_calc        = ROLE_VALUE;
          value_count_next = 16'd1;
          phase_next       = PH_VAL;
        end
      end
      PH_VAL: begin
        role_calc = ROLE_VALUE;
        if (value_count != 16'hFFFF) begin
          value_count_next = value_count + 16'd1;
        end
      end
      default: begin
      end
    endcase

    missing = arg_error_next || phase_next == PH_KEY_START || phase_next == PH_SKIP ||
              phase_next == PH_VAL_START ||
              (phase_next == PH_KEY && matched_kind_next == KIND_SET);
    key_ext = ExtW'(key_count_next);
    kind_calc = KIND_PARSE;
    klen_calc = '0;
    vlen_calc = '0;
    if (last_byte && matched_kind_next != KIND_PARSE && phase_next != PH_CMD) begin
      kind_calc = missing ? KIND_ARG : matched_kind_next;
      klen_calc = (key_ext > ExtW'(KEY_LEN_CAP)) ? KEY_LEN_CAP : key_ext[8:0];
      vlen_calc = missing ? 16'd0 : value_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CMD;
      position       <= '0;
      candidate_mask <= '1;
      key_count      <= '0;
      value_count    <= '0;
      arg_error      <= 1'b0;
      matched_kind   <= KIND_PARSE;
      out_valid      <= 1'b0;
    end else begin
      if (in_accept) begin
        if (last_byte) begin
          phase          <= PH_CMD;
          position       <= '0;
          candidate_mask <= '1;
          key_count      <= '0;
          value_count    <= '0;
          arg_error      <= 1'b0;
          matched_kind   <= KIND_PARSE;
        end else begin
          phase          <= phase_next;
          position       <= position_next;
          candidate_mask <= candidate_mask_next;
          key_count      <= key_count_next;
          value_count    <= value_count_next;
          arg_error      <= arg_error_next;
          matched_kind   <= matched_kind_next;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_echo    <= data_byte;
      byte_role    <= role_calc;
      line_done    <= last_byte;
      request_kind <= kind_calc;
      key_length   <= klen_calc;
      value_length <= vlen_calc;
    end
  end

`ifndef SYNTH
  a_mid_line_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_done |-> request_kind == KIND_PARSE && key_length == '0 &&
    value_length == '0)
    else $error("summary fields set on a non-final byte");

  a_parse_err_no_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done && request_kind == KIND_PARSE |->
    key_length == '0 && value_length == '0)
    else $error("lengths reported with a parse error");

  a_value_only_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && value_length != '0 |-> request_kind == KIND_SET)
    else $error("value length reported for a non-SET request");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_byte |=> phase == PH_CMD && key_count == '0 &&
    value_count == '0 && candidate_mask == '1)
    else $error("parse state not restarted after last byte");

  a_value_role_after_key: assert property (@(posedge clk) disable iff (rst)
    in_accept && role_calc == ROLE_VALUE |-> matched_kind == KIND_SET && key_count != '0)
    else $error("value byte without a SET key");
`endif

endmodule

@@ tb/tb_kv_command_line_parser.sv @@
// Testbench for kv_command_line_parser: directed and random command lines, bursty
// sender, patterned receiver stall, per-byte checks against an in-bench predictor.
// Depends on kvclp_pkg and the kv_command_line_parser RTL.
`timescale 1ns / 100ps

module tb_kv_command_line_parser;
  import kvclp_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int LINE_CAP   = 65535;
  localparam int VALUE_CAP  = 65535;

  typedef enum logic [2:0] {
    SCAN_COMMAND, SCAN_KEY_HEAD, SCAN_KEY, SCAN_SKIP, SCAN_VALUE_HEAD, SCAN_VALUE, SCAN_TAIL
  } scan_phase_t;

  typedef struct packed {
    logic [7:0]  echo;
    role_t       role;
    logic        done;
    kind_t       kind;
    logic [8:0]  klen;
    logic [15:0] vlen;
  } byte_result_t;

  class parse_scoreboard;
    byte_result_t predicted_bytes[$];
    int          mismatches;
    int          key_cap;
    int          pos;
    logic [7:0]  live;
    scan_phase_t phase;
    int          key_cnt;
    int          val_cnt;
    bit          arg_bad;
    kind_t       hit_kind;

    function new(int cap);
      key_cap    = cap;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      pos      = 0;
      live     = 8'hFF;
      phase    = SCAN_COMMAND;
      key_cnt  = 0;
      val_cnt  = 0;
      arg_bad  = 1'b0;
      hit_kind = KIND_PARSE;
    endfunction

    function void key_limit();
      if (key_cnt >= key_cap) phase = (hit_kind == KIND_SET) ? SCAN_SKIP : SCAN_TAIL;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      byte_result_t r;
      bit           missing;
      r      = '0;
      r.echo = b;
      r.role = ROLE_NONE;
      r.done = last;
      case (phase)
        SCAN_COMMAND: begin
          for (int i = 0; i < NUM_CAND; i++) begin
            if (!live[i]) continue;
            if (pos >= int'(CAND_LEN[i]) || CAND_TEXT[i][pos] != b) begin
              live[i] = 1'b0;
              continue;
            end
            if (pos + 1 == int'(CAND_LEN[i])) begin
              if (i < NUM_PREFIX) begin
                hit_kind = CAND_KIND[i];
                phase    = SCAN_KEY_HEAD;
              end else if (last) begin
                hit_kind = CAND_KIND[i];
                phase    = SCAN_TAIL;
              end else begin
                live[i] = 1'b0;
              end
            end
          end
          if (phase == SCAN_COMMAND && live == 8'h00) begin
            hit_kind = KIND_PARSE;
            phase    = SCAN_TAIL;
          end
        end
        SCAN_KEY_HEAD: begin
          if (b == CHAR_SPACE) begin
            arg_bad = 1'b1;
            phase   = SCAN_TAIL;
          end else begin
            r.role  = ROLE_KEY;
            key_cnt = 1;
            phase   = SCAN_KEY;
            key_limit();
          end
        end
        SCAN_KEY: begin
          if (b == CHAR_SPACE) begin
            phase = (hit_kind == KIND_SET) ? SCAN_VALUE_HEAD : SCAN_TAIL;
          end else begin
            r.role = ROLE_KEY;
            key_cnt++;
            key_limit();
          end
        end
        SCAN_SKIP: phase = SCAN_VALUE_HEAD;
        SCAN_VALUE_HEAD: begin
          if (b == CHAR_SPACE) begin
            arg_bad = 1'b1;
            phase   = SCAN_TAIL;
          end else begin
            r.role  = ROLE_VALUE;
            val_cnt = 1;
            phase   = SCAN_VALUE;
          end
        end
        SCAN_VALUE: begin
          r.role = ROLE_VALUE;
          if (val_cnt < VALUE_CAP) val_cnt++;
        end
        default: ;
      endcase
      if (pos < LINE_CAP) pos++;
      if (last) begin
        if (hit_kind == KIND_PARSE || phase == SCAN_COMMAND) begin
          r.kind = KIND_PARSE;
        end else begin
          missing = arg_bad || phase == SCAN_KEY_HEAD || phase == SCAN_SKIP ||
                    phase == SCAN_VALUE_HEAD || (phase == SCAN_KEY && hit_kind == KIND_SET);
          r.kind = missing ? KIND_ARG : hit_kind;
          r.klen = (key_cnt > int'(KEY_LEN_CAP)) ? KEY_LEN_CAP : 9'(key_cnt);
          r.vlen = missing ? 16'd0 : 16'(val_cnt);
        end
        clear_line();
      end
      predicted_bytes.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [7:0] echo, role_t role, logic done, kind_t kind,
                               logic [8:0] klen, logic [15:0] vlen);
      byte_result_t want;
      if (predicted_bytes.size() == 0) begin
        $error("result with no transaction pending: byte_echo %0h", echo);
        mismatches++;
        return;
      end
      want = predicted_bytes.pop_front();
      compare_field("byte_echo", 16'(want.echo), 16'(echo));
      compare_field("byte_role", 16'(want.role), 16'(role));
      compare_field("line_done", 16'(want.done), 16'(done));
      compare_field("request_kind", 16'(want.kind), 16'(kind));
      compare_field("key_length", 16'(want.klen), 16'(klen));
      compare_field("value_length", want.vlen, vlen);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  byte_echo;
  role_t       byte_role;
  logic        line_done;
  kind_t       request_kind;
  logic [8:0]  key_length;
  logic [15:0] value_length;

  parse_scoreboard sb;
  logic [7:0]      line_buf[$];
  int              burst_left = 0;

  kv_command_line_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_echo    (byte_echo),
    .byte_role    (byte_role),
    .line_done    (line_done),
    .request_kind (request_kind),
    .key_length   (key_length),
    .value_length (value_length)
  );

  always #10 clk = ~clk;

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_bytes(int n, bit no_space);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255)); while (no_space && b == CHAR_SPACE);
      line_buf.push_back(b);
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, last);
    burst_left--;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic send_text(string s);
    line_buf.delete();
    add_text(s);
    send_line();
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.predicted_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic build_random_line();
    int cmd;
    int klen;
    int cut;
    line_buf.delete();
    if ($urandom_range(0, 19) == 0) begin
      add_bytes($urandom_range(1, 12), 1'b0);
      return;
    end
    cmd = $urandom_range(0, NUM_CAND - 1);
    for (int i = 0; i < int'(CAND_LEN[cmd]); i++) line_buf.push_back(CAND_TEXT[cmd][i]);
    if (cmd < NUM_PREFIX) begin
      klen = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 10);
      if ($urandom_range(0, 15) == 0) line_buf.push_back(CHAR_SPACE);
      add_bytes(klen, 1'b1);
      if (CAND_KIND[cmd] == KIND_SET) begin
        if (klen < KEY_MAX_DEF) line_buf.push_back(CHAR_SPACE);
        else add_bytes(1, 1'b0);
        if ($urandom_range(0, 15) == 0) line_buf.push_back(CHAR_SPACE);
        add_bytes(1, 1'b1);
        add_bytes($urandom_range(0, 23), 1'b0);
      end else if ($urandom_range(0, 3) == 0) begin
        line_buf.push_back(CHAR_SPACE);
        add_bytes($urandom_range(1, 6), 1'b0);
      end
    end else if ($urandom_range(0, 5) == 0) begin
      add_bytes(1, 1'b0);
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, line_buf.size());
      while (line_buf.size() > cut) void'(line_buf.pop_back());
    end
    if ($urandom_range(0, 9) == 0) line_buf[$urandom_range(0, line_buf.size() - 1)] =
      8'($urandom_range(0, 255));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(byte_echo, byte_role, line_done, request_kind, key_length, value_length);
  end

  initial begin
    int cyc;
    int hold_left;
    int mode_left;
    int stall_pct;
    cyc       = 0;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 1500 == 700) hold_left = 120;
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 75;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int random_bytes;
    int line_no;
    sb = new(KEY_MAX_DEF);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("GET k1");
    send_text("SET ab xyz");
    send_text("DEL d");
    send_text("INCR ctr");
    send_text("DECR ctr");
    send_text("URL u");
    send_text("FLUSH");
    send_text("INFO");
    send_text("FLUSHY");
    send_text("INFO ");
    send_text("INCR");
    send_text("GET ");
    send_text("DEL  x");
    send_text("SET k");
    send_text("SET k ");
    send_text("SET k  v");
    send_text("HELLO");
    send_text("GE");
    send_text("X");
    send_text("URL key extra tail");

    line_buf.delete();
    add_text("SET ");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(CHAR_SPACE);
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    send_line();

    line_buf.delete();
    add_text("GET ");
    add_bytes(KEY_MAX_DEF, 1'b1);
    add_text("zz");
    send_line();

    line_buf.delete();
    add_text("SET ");
    add_bytes(KEY_MAX_DEF, 1'b1);
    add_text("Qv");
    send_line();

    line_buf.delete();
    add_text("SET ");
    add_bytes(KEY_MAX_DEF, 1'b1);
    send_line();

    random_bytes = 0;
    line_no      = 0;
    while (random_bytes < 300) begin
      build_random_line();
      random_bytes += line_buf.size();
      send_line();
      line_no++;
      if (line_no == 10 || $urandom_range(0, 39) == 0) drain_pause();
    end

    drain_pause();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.predicted_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/kvclp_pkg.sv
sv/kv_command_line_parser.sv
tb/tb_kv_command_line_parser.sv
